/* design/tbo_pkg.sv */
// package: widths and defaults for the triangle/box overlap test
`timescale 1ns / 1ps
package tbo_pkg;
  localparam int COORD_WIDTH = 16;
  localparam int HALF_RESET = 256;
  localparam int REG_HALF_X = 0;
  localparam int REG_HALF_Y = 1;
  localparam int REG_HALF_Z = 2;
endpackage

/* design/triangle_box_overlap_test_top.sv */
// top level: pipelined triangle versus box separating axis test
//
// channel | dir | contents
// s_axis  | in  | tdata: center xyz, vert0 xyz, vert1 xyz, vert2 xyz (W bits each, low first)
// m_axis  | out | tdata: overlap (bit 0), zero filled to 8 bits
// apb     | in  | half_size_x/y/z at byte 0, 4, 8
//
// one item per cycle while m_axis is not stalled; five register stages
// (translate, edges, products, sums/compares, plane dot products + result)
// rst clears all valid bits and sets half sizes to 256
// a stall on m_axis holds every stage; tready is high when the last
// stage is empty or being drained, so no item is lost or repeated
`timescale 1ns / 1ps
module triangle_box_overlap_test_top #(
  parameter int COORD_WIDTH = tbo_pkg::COORD_WIDTH
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // center_x, center_y, center_z, vert0_x..z, vert1_x..z, vert2_x..z
  input  logic [((12*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // overlap
  output logic [7:0] m_axis_tdata,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [3:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  localparam int W  = COORD_WIDTH;
  localparam int HW = COORD_WIDTH - 1;
  localparam int VW = W + 2;      // translated vertex
  localparam int EW = W + 3;      // edge
  localparam int PW = 2*EW + 2;   // projection, radius, normal
  localparam int DW = PW + VW + 4; // plane dot product

  // configuration registers
  logic [HW-1:0] half [3];
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 3; k++) half[k] <= HW'(tbo_pkg::HALF_RESET);
    end else if (psel && penable && pwrite) begin
      case (paddr)
        4'(4*tbo_pkg::REG_HALF_X): half[0] <= pwdata[HW-1:0];
        4'(4*tbo_pkg::REG_HALF_Y): half[1] <= pwdata[HW-1:0];
        4'(4*tbo_pkg::REG_HALF_Z): half[2] <= pwdata[HW-1:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    case (paddr)
      4'(4*tbo_pkg::REG_HALF_X): prdata = 32'(half[0]);
      4'(4*tbo_pkg::REG_HALF_Y): prdata = 32'(half[1]);
      4'(4*tbo_pkg::REG_HALF_Z): prdata = 32'(half[2]);
      default: prdata = '0;
    endcase
  end

  // pipeline enable: whole pipe advances unless the output is stalled
  logic adv;
  logic [4:0] vld;
  assign adv = !vld[4] || m_axis_tready;
  assign s_axis_tready = adv;
  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (adv) vld <= {vld[3:0], s_axis_tvalid};
  end

  // stage 1: translate vertices to the box center
  logic signed [VW-1:0] v1 [3][3];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int t = 0; t < 3; t++)
        for (int k = 0; k < 3; k++)
          v1[t][k] <= VW'($signed(s_axis_tdata[(3+3*t+k)*W +: W]))
                    - VW'($signed(s_axis_tdata[k*W +: W]));
    end
  end

  // stage 2: edges, extent tests
  logic signed [VW-1:0] v2 [3][3];
  logic signed [EW-1:0] e2 [3][3];
  logic box_sep2;
  always_ff @(posedge clk) begin
    if (adv) begin
      automatic logic bs = 1'b0;
      for (int k = 0; k < 3; k++) begin
        e2[0][k] <= EW'(v1[1][k]) - EW'(v1[0][k]);
        e2[1][k] <= EW'(v1[2][k]) - EW'(v1[1][k]);
        e2[2][k] <= EW'(v1[0][k]) - EW'(v1[2][k]);
        if ((v1[0][k] > $signed({1'b0, half[k]}) && v1[1][k] > $signed({1'b0, half[k]})
             && v1[2][k] > $signed({1'b0, half[k]}))
         || (v1[0][k] < -$signed(VW'(half[k])) && v1[1][k] < -$signed(VW'(half[k]))
             && v1[2][k] < -$signed(VW'(half[k]))))
          bs = 1'b1;
      end
      box_sep2 <= bs;
      v2 <= v1;
    end
  end

  // stage 3: all products (36 projection terms, 18 radius terms, 6 normal terms)
  // axis table: edge, vertex a, vertex b, axis k
  function automatic int ax_e(input int a); return a / 3; endfunction
  function automatic int ax_k(input int a); return a % 3; endfunction
  function automatic int ax_vb(input int a);
    case (a)
      5: return 1; 6: return 1; 7: return 1;
      default: return 2;
    endcase
  endfunction
  function automatic int ax_va2(input int a);
    return (a == 2 || a == 8) ? 1 : 0;
  endfunction
  logic signed [PW-1:0] pa3 [9][2], pb3 [9][2], r3 [9][2], n3 [3][2];
  logic signed [VW-1:0] v3 [3];
  logic box_sep3;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int a = 0; a < 9; a++) begin
        automatic int ei = (ax_k(a) + 1) % 3;
        automatic int ej = (ax_k(a) + 2) % 3;
        automatic logic signed [EW-1:0] ex = e2[ax_e(a)][ej];
        automatic logic signed [EW-1:0] ey = e2[ax_e(a)][ei];
        automatic logic signed [EW-1:0] ex_abs = (ex < 0) ? -ex : ex;
        automatic logic signed [EW-1:0] ey_abs = (ey < 0) ? -ey : ey;
        pa3[a][0] <= PW'(ex) * PW'(v2[ax_va2(a)][ei]);
        pa3[a][1] <= PW'(ey) * PW'(v2[ax_va2(a)][ej]);
        pb3[a][0] <= PW'(ex) * PW'(v2[ax_vb(a)][ei]);
        pb3[a][1] <= PW'(ey) * PW'(v2[ax_vb(a)][ej]);
        r3[a][0] <= PW'(ex_abs) * PW'($signed({1'b0, half[ei]}));
        r3[a][1] <= PW'(ey_abs) * PW'($signed({1'b0, half[ej]}));
      end
      for (int k = 0; k < 3; k++) begin
        n3[k][0] <= PW'(e2[0][(k+1)%3]) * PW'(e2[1][(k+2)%3]);
        n3[k][1] <= PW'(e2[0][(k+2)%3]) * PW'(e2[1][(k+1)%3]);
        v3[k] <= v2[0][k];
      end
      box_sep3 <= box_sep2;
    end
  end

  // stage 4: sums and axis compares, plane corners
  logic sep4;
  logic signed [PW-1:0] n4 [3];
  logic signed [VW:0] lo4 [3], hi4 [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      automatic logic s = box_sep3;
      for (int a = 0; a < 9; a++) begin
        automatic logic signed [PW-1:0] pa = pa3[a][0] - pa3[a][1];
        automatic logic signed [PW-1:0] pb = pb3[a][0] - pb3[a][1];
        automatic logic signed [PW-1:0] rd = r3[a][0] + r3[a][1];
        automatic logic signed [PW-1:0] mn = pa < pb ? pa : pb;
        automatic logic signed [PW-1:0] mx = pa < pb ? pb : pa;
        if (rd < mn || mx < -rd) s = 1'b1;
      end
      sep4 <= s;
      for (int k = 0; k < 3; k++) begin
        automatic logic signed [PW-1:0] nk = n3[k][0] - n3[k][1];
        automatic logic signed [VW:0] hp = $signed({2'b0, half[k]}) - (VW+1)'(v3[k]);
        automatic logic signed [VW:0] hn = -$signed({2'b0, half[k]}) - (VW+1)'(v3[k]);
        n4[k] <= nk;
        lo4[k] <= (nk > 0) ? hn : hp;
        hi4[k] <= (nk > 0) ? hp : hn;
      end
    end
  end

  // stage 5: plane dot products and final decision
  logic ovl5;
  always_ff @(posedge clk) begin
    if (adv) begin
      automatic logic signed [DW-1:0] dmin = '0;
      automatic logic signed [DW-1:0] dmax = '0;
      for (int k = 0; k < 3; k++) begin
        dmin = dmin + DW'(n4[k]) * DW'(lo4[k]);
        dmax = dmax + DW'(n4[k]) * DW'(hi4[k]);
      end
      ovl5 <= !sep4 && !(dmin > 0) && !(dmax < 0);
    end
  end

  assign m_axis_tvalid = vld[4];
  assign m_axis_tdata = {7'b0, ovl5};
endmodule

/* tb/triangle_box_overlap_test_top_checker.sv */
// checker: watches the item channels, predicts the overlap bit and compares
`timescale 1ns / 1ps
module triangle_box_overlap_test_top_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [191:0] s_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [7:0]   m_axis_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  input  logic         pready,
  output int           fail_count,
  output int           pending_count,
  output int           result_count,
  output int           overlap_count
);
  typedef logic signed [127:0] wide_t;

  logic [14:0] half_x, half_y, half_z;
  logic expected_overlap_q[$];

  assign pending_count = expected_overlap_q.size();

  // one edge cross axis test: true when that axis separates
  function automatic logic edge_axis_separates(wide_t ej, wide_t ei, wide_t vai, wide_t vaj,
                                               wide_t vbi, wide_t vbj, wide_t hi_, wide_t hj_);
    wide_t pa, pb, rad, mn, mx;
    pa = ej * vai - ei * vaj;
    pb = ej * vbi - ei * vbj;
    rad = (ej < 0 ? -ej : ej) * hi_ + (ei < 0 ? -ei : ei) * hj_;
    mn = (pa < pb) ? pa : pb;
    mx = (pa < pb) ? pb : pa;
    return (mn > rad) || (mx < -rad);
  endfunction

  // full separating axis overlap prediction for one triangle
  function automatic logic predict_overlap(logic [191:0] d);
    wide_t c[3], v[3][3], e[3][3], h[3], n[3], dmin, dmax, lo, hi;
    int i, j;
    h[0] = half_x; h[1] = half_y; h[2] = half_z;
    for (int k = 0; k < 3; k++) c[k] = $signed(d[16*k +: 16]);
    for (int t = 0; t < 3; t++)
      for (int k = 0; k < 3; k++)
        v[t][k] = wide_t'($signed(d[16*(3+3*t+k) +: 16])) - c[k];
    for (int k = 0; k < 3; k++) begin
      e[0][k] = v[1][k] - v[0][k];
      e[1][k] = v[2][k] - v[1][k];
      e[2][k] = v[0][k] - v[2][k];
    end
    for (int ed = 0; ed < 3; ed++)
      for (int k = 0; k < 3; k++) begin
        int a, b;
        i = (k + 1) % 3; j = (k + 2) % 3;
        // spanning vertex pair per edge and axis, in the classic order
        case (ed)
          0: begin a = (k == 2) ? 1 : 0; b = 2; end
          1: begin a = 0; b = (k == 2) ? 1 : 2; end
          default: begin a = (k == 2) ? 1 : 0; b = (k == 2) ? 2 : 1; end
        endcase
        if (edge_axis_separates(e[ed][j], e[ed][i], v[a][i], v[a][j], v[b][i], v[b][j],
                                h[i], h[j]))
          return 1'b0;
      end
    // box axis extents
    for (int k = 0; k < 3; k++) begin
      lo = v[0][k]; hi = v[0][k];
      for (int t = 1; t < 3; t++) begin
        if (v[t][k] < lo) lo = v[t][k];
        if (v[t][k] > hi) hi = v[t][k];
      end
      if (lo > h[k] || hi < -h[k]) return 1'b0;
    end
    // triangle plane against box corners
    for (int k = 0; k < 3; k++) begin
      i = (k + 1) % 3; j = (k + 2) % 3;
      n[k] = e[0][i] * e[1][j] - e[0][j] * e[1][i];
    end
    dmin = 0; dmax = 0;
    for (int q = 0; q < 3; q++) begin
      if (n[q] > 0) begin
        dmin += n[q] * (-h[q] - v[0][q]);
        dmax += n[q] * (h[q] - v[0][q]);
      end else begin
        dmin += n[q] * (h[q] - v[0][q]);
        dmax += n[q] * (-h[q] - v[0][q]);
      end
    end
    if (dmin > 0) return 1'b0;
    return dmax >= 0;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      half_x <= 15'(tbo_pkg::HALF_RESET);
      half_y <= 15'(tbo_pkg::HALF_RESET);
      half_z <= 15'(tbo_pkg::HALF_RESET);
      fail_count <= 0;
      result_count <= 0;
      overlap_count <= 0;
      expected_overlap_q.delete();
    end else begin
      // register writes
      if (psel && penable && pwrite && pready) begin
        case (paddr)
          4'(4 * tbo_pkg::REG_HALF_X): half_x <= pwdata[14:0];
          4'(4 * tbo_pkg::REG_HALF_Y): half_y <= pwdata[14:0];
          4'(4 * tbo_pkg::REG_HALF_Z): half_z <= pwdata[14:0];
          default: ;
        endcase
      end
      // accepted triangle
      if (s_axis_tvalid && s_axis_tready)
        expected_overlap_q.push_back(predict_overlap(s_axis_tdata));
      // accepted result
      if (m_axis_tvalid && m_axis_tready) begin
        result_count <= result_count + 1;
        if (m_axis_tdata[0]) overlap_count <= overlap_count + 1;
        if (expected_overlap_q.size() == 0) begin
          $error("unexpected result item, overlap=%0d", m_axis_tdata[0]);
          fail_count <= fail_count + 1;
        end else if (m_axis_tdata !== {7'd0, expected_overlap_q[0]}) begin
          $error("overlap mismatch: expected %0d actual %0d",
                 expected_overlap_q[0], m_axis_tdata);
          fail_count <= fail_count + 1;
          void'(expected_overlap_q.pop_front());
        end else begin
          void'(expected_overlap_q.pop_front());
        end
      end
    end
  end
endmodule

/* tb/triangle_box_overlap_test_top_test.sv */
// testbench top: stimulus, register phases and verdict for the overlap test
`timescale 1ns / 1ps
module triangle_box_overlap_test_top_test;
  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  // center_x..z, vert0_x..z, vert1_x..z, vert2_x..z (16 bits each, low first)
  logic [191:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // overlap in bit 0, zero filled
  logic [7:0]   m_axis_tdata;
  logic         psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;
  int fail_count, pending_count, result_count, overlap_count;
  int triangle_count = 0;
  bit calm_stretch = 0;
  logic signed [15:0] tri_fields[12];

  always #4 clk = ~clk;

  triangle_box_overlap_test_top u_top (.*);

  triangle_box_overlap_test_top_checker u_checker (.*);

  // result side stalls
  always @(negedge clk)
    m_axis_tready <= rst ? 1'b0 : (calm_stretch || $urandom_range(99) >= 25);

  // one apb write while idle
  task automatic write_half(input logic [3:0] addr, input logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic set_box(input logic [31:0] hx, input logic [31:0] hy, input logic [31:0] hz);
    write_half(4'(4 * tbo_pkg::REG_HALF_X), hx);
    write_half(4'(4 * tbo_pkg::REG_HALF_Y), hy);
    write_half(4'(4 * tbo_pkg::REG_HALF_Z), hz);
  endtask

  // send tri_fields as one item, with random idle first
  task automatic send_triangle();
    logic [191:0] item_data;
    while (!calm_stretch && $urandom_range(99) < 25) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    for (int k = 0; k < 12; k++) item_data[16*k +: 16] = tri_fields[k];
    s_axis_tdata <= item_data;
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
    triangle_count++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  // random triangle near the box center, scaled by span
  task automatic random_triangle(input int span);
    int cx[3];
    for (int k = 0; k < 3; k++) begin
      cx[k] = $signed(16'($urandom));
      tri_fields[k] = 16'(cx[k]);
    end
    for (int k = 3; k < 12; k++)
      if (span >= 65536) tri_fields[k] = 16'($urandom);
      else tri_fields[k] = 16'(cx[(k - 3) % 3] + $urandom_range(2 * span) - span);
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: extremes, touching faces, degenerate triangles
    tri_fields = '{default: 16'sd0};
    send_triangle();
    tri_fields = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff,
                   16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000};
    send_triangle();
    tri_fields = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000,
                   16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000};
    send_triangle();
    // triangle touching the +x face exactly, and one just past it
    tri_fields = '{16'sd0, 16'sd0, 16'sd0, 16'sd256, 16'sd0, 16'sd0,
                   16'sd256, 16'sd100, 16'sd0, 16'sd256, 16'sd0, 16'sd100};
    send_triangle();
    tri_fields = '{16'sd0, 16'sd0, 16'sd0, 16'sd257, 16'sd0, 16'sd0,
                   16'sd257, 16'sd100, 16'sd0, 16'sd257, 16'sd0, 16'sd100};
    send_triangle();
    // plane touching a box corner
    tri_fields = '{16'sd0, 16'sd0, 16'sd0, 16'sd768, 16'sd0, 16'sd0,
                   16'sd0, 16'sd768, 16'sd0, 16'sd0, 16'sd0, 16'sd768};
    send_triangle();
    tri_fields = '{16'sd0, 16'sd0, 16'sd0, 16'sd769, 16'sd0, 16'sd0,
                   16'sd0, 16'sd769, 16'sd0, 16'sd0, 16'sd0, 16'sd769};
    send_triangle();
    // degenerate: point and segment
    tri_fields = '{16'sd0, 16'sd0, 16'sd0, 16'sd10, 16'sd10, 16'sd10,
                   16'sd10, 16'sd10, 16'sd10, 16'sd10, 16'sd10, 16'sd10};
    send_triangle();
    tri_fields = '{16'sd0, 16'sd0, 16'sd0, -16'sd300, 16'sd0, 16'sd0,
                   16'sd300, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0};
    send_triangle();
    tri_fields = '{16'sd0, 16'sd0, 16'sd0, 16'sd300, 16'sd300, 16'sd300,
                   16'sd400, 16'sd400, 16'sd400, 16'sd500, 16'sd500, 16'sd500};
    send_triangle();
    drain();

    // zero box with too wide values masked; then maximum box
    set_box(32'hffff_0000, 32'h8000, 32'h0);
    tri_fields = '{16'sd5, 16'sd5, 16'sd5, 16'sd5, 16'sd5, 16'sd5,
                   16'sd6, 16'sd5, 16'sd5, 16'sd5, 16'sd6, 16'sd5};
    send_triangle();
    tri_fields = '{16'sd5, 16'sd5, 16'sd5, 16'sd6, 16'sd5, 16'sd5,
                   16'sd7, 16'sd5, 16'sd5, 16'sd6, 16'sd6, 16'sd5};
    send_triangle();
    for (int n = 0; n < 4; n++) begin random_triangle(65536); send_triangle(); end
    drain();
    set_box(32'h7fff, 32'h7fff, 32'h7fff);
    for (int n = 0; n < 4; n++) begin random_triangle(65536); send_triangle(); end
    drain();
    write_half(4'hc, 32'h5);

    // random phases over several box sizes
    for (int phase = 0; phase < 6; phase++) begin
      int hs;
      hs = (phase == 0) ? 0 : (phase == 5) ? 32767 : (1 << (2 * phase + 3));
      set_box($urandom_range(hs), $urandom_range(hs), $urandom_range(hs));
      for (int n = 0; n < 230; n++) begin
        calm_stretch = (phase == 2 && n < 100);
        random_triangle(n % 7 == 0 ? 65536 : (n % 2 ? 2 * hs + 8 : 4 * hs + 64));
        send_triangle();
      end
      calm_stretch = 0;
      drain();
    end

    $display("sent %0d triangles over 9 box settings; %0d of %0d results overlapped",
             triangle_count, overlap_count, result_count);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Mismatches found");
    $finish;
  end
endmodule

/* triangle_box_overlap_test_top.f */
design/tbo_pkg.sv
design/triangle_box_overlap_test_top.sv
tb/triangle_box_overlap_test_top_checker.sv
tb/triangle_box_overlap_test_top_test.sv
